@@ src/hcbd_pkg.sv @@
package hcbd_pkg;

  // Line limit registers
  localparam int unsigned LIMIT_W = 17;
  localparam int unsigned LINE_CNT_W = 18;
  localparam logic [LIMIT_W-1:0] EXT_LINE_LIMIT_RST = 17'd8192;
  localparam logic [LIMIT_W-1:0] TRAILER_LINE_LIMIT_RST = 17'd65536;
  localparam logic [LINE_CNT_W-1:0] LINE_CNT_MAX = 18'h3FFFF;

  // Configuration register indexes
  localparam logic CFG_EXT_LINE_LIMIT = 1'b0;
  localparam logic CFG_TRAILER_LINE_LIMIT = 1'b1;

  // Byte classes
  localparam logic [2:0] CLS_SIZE_DIGIT = 3'd0;
  localparam logic [2:0] CLS_EXT = 3'd1;
  localparam logic [2:0] CLS_SIZE_CRLF = 3'd2;
  localparam logic [2:0] CLS_DATA = 3'd3;
  localparam logic [2:0] CLS_DATA_CRLF = 3'd4;
  localparam logic [2:0] CLS_TRAILER = 3'd5;
  localparam logic [2:0] CLS_FINAL_CRLF = 3'd6;
  localparam logic [2:0] CLS_NONE = 3'd7;

  // Error codes
  localparam logic [2:0] ERR_OK = 3'd0;
  localparam logic [2:0] ERR_BAD_SIZE_CHAR = 3'd1;
  localparam logic [2:0] ERR_SIZE_OVERFLOW = 3'd2;
  localparam logic [2:0] ERR_EXT_LINE = 3'd3;
  localparam logic [2:0] ERR_MISSING_CRLF = 3'd4;
  localparam logic [2:0] ERR_TRAILER_LINE = 3'd5;

  // Characters
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_SEMI = 8'h3B;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       start_of_body;
  } in_item_t;

  typedef struct packed {
    logic       consumed;
    logic [2:0] byte_class;
    logic       body_done;
    logic [2:0] error_code;
  } out_item_t;

endpackage

@@ src/http_chunked_body_deframer.sv @@
// A byte passes through the input register, then the result register.
// Throughput: one byte per cycle while the output is not stalled; the parser state
// updates as a byte moves from the input register into the result register.
// Reset (rst, synchronous): parser back to the size state, error and done clear,
// ext_line_limit = 8192, trailer_line_limit = 65536.
module http_chunked_body_deframer #(
  parameter int unsigned SIZE_BITS = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  hcbd_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output hcbd_pkg::out_item_t              out_data,
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [hcbd_pkg::LIMIT_W-1:0]     cfg_data
);

  typedef enum logic [3:0] {
    PH_SIZE     = 4'd0,
    PH_EXT      = 4'd1,
    PH_SIZE_LF  = 4'd2,
    PH_DATA     = 4'd3,
    PH_DATA_CR  = 4'd4,
    PH_DATA_LF  = 4'd5,
    PH_TR_START = 4'd6,
    PH_TR       = 4'd7,
    PH_TR_LF    = 4'd8,
    PH_FINAL_LF = 4'd9,
    PH_DONE     = 4'd10
  } phase_t;

  logic [hcbd_pkg::LIMIT_W-1:0]    ext_line_limit;
  logic [hcbd_pkg::LIMIT_W-1:0]    trailer_line_limit;

  phase_t                          phase, phase_next, cur_phase;
  logic [SIZE_BITS-1:0]            chunk_size_acc, chunk_size_acc_next, cur_acc;
  logic [SIZE_BITS-1:0]            data_left, data_left_next, cur_left;
  logic [hcbd_pkg::LINE_CNT_W-1:0] line_count, line_count_next, cur_count, count_inc;
  logic                            saw_digit, saw_digit_next, cur_saw;
  logic [2:0]                      error_held, error_held_next, cur_err;

  logic                            s1_valid;
  hcbd_pkg::in_item_t              s1_item;
  logic                            advance;
  logic                            in_take;

  logic                            take;
  logic [2:0]                      cls;
  logic [2:0]                      err;
  logic                            digit_ok;
  logic [3:0]                      digit_val;
  logic [7:0]                      b;

  // Handshake: the result register frees whenever it is empty or being taken
  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  // Decode a hex digit
  always_comb begin
    b = s1_item.byte_in;
    digit_ok  = 1'b0;
    digit_val = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      digit_ok  = 1'b1;
      digit_val = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      digit_ok  = 1'b1;
      digit_val = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      digit_ok  = 1'b1;
      digit_val = 4'(b - 8'h37);
    end
  end

  // Parser next state for the byte in the input register
  always_comb begin
    if (s1_item.start_of_body) begin
      cur_phase = PH_SIZE;
      cur_acc   = '0;
      cur_left  = '0;
      cur_count = '0;
      cur_saw   = 1'b0;
      cur_err   = hcbd_pkg::ERR_OK;
    end else begin
      cur_phase = phase;
      cur_acc   = chunk_size_acc;
      cur_left  = data_left;
      cur_count = line_count;
      cur_saw   = saw_digit;
      cur_err   = error_held;
    end

    count_inc = (cur_count == hcbd_pkg::LINE_CNT_MAX) ? cur_count : cur_count + 1'b1;

    phase_next          = cur_phase;
    chunk_size_acc_next = cur_acc;
    data_left_next      = cur_left;
    line_count_next     = cur_count;
    saw_digit_next      = cur_saw;
    take = 1'b0;
    cls  = hcbd_pkg::CLS_NONE;
    err  = hcbd_pkg::ERR_OK;

    if (cur_err == hcbd_pkg::ERR_OK) begin
      case (cur_phase)
        PH_SIZE: begin
          if (digit_ok) begin
            // Overflow when any of the top four bits is set before the shift
            if (cur_acc[SIZE_BITS-1 -: 4] != 4'd0) begin
              err = hcbd_pkg::ERR_SIZE_OVERFLOW;
            end else begin
              chunk_size_acc_next = {cur_acc[SIZE_BITS-5:0], digit_val};
              saw_digit_next      = 1'b1;
              line_count_next     = count_inc;
              take = 1'b1;
              cls  = hcbd_pkg::CLS_SIZE_DIGIT;
            end
          end else if (b == hcbd_pkg::CHAR_SEMI && cur_saw) begin
            phase_next      = PH_EXT;
            line_count_next = count_inc;
            take = 1'b1;
            cls  = hcbd_pkg::CLS_EXT;
          end else if (b == hcbd_pkg::CHAR_CR && cur_saw) begin
            phase_next = PH_SIZE_LF;
            take = 1'b1;
            cls  = hcbd_pkg::CLS_SIZE_CRLF;
          end else begin
            err = hcbd_pkg::ERR_BAD_SIZE_CHAR;
          end
        end
        PH_EXT: begin
          line_count_next = count_inc;
          if (count_inc > {1'b0, ext_line_limit} || b == hcbd_pkg::CHAR_LF) begin
            err = hcbd_pkg::ERR_EXT_LINE;
          end else begin
            take = 1'b1;
            if (b == hcbd_pkg::CHAR_CR) begin
              phase_next = PH_SIZE_LF;
              cls = hcbd_pkg::CLS_SIZE_CRLF;
            end else begin
              cls = hcbd_pkg::CLS_EXT;
            end
          end
        end
        PH_SIZE_LF: begin
          if (b != hcbd_pkg::CHAR_LF) begin
            err = hcbd_pkg::ERR_MISSING_CRLF;
          end else begin
            take = 1'b1;
            cls  = hcbd_pkg::CLS_SIZE_CRLF;
            if (cur_acc == '0) begin
              phase_next = PH_TR_START;
            end else begin
              data_left_next = cur_acc;
              phase_next     = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          take = 1'b1;
          cls  = hcbd_pkg::CLS_DATA;
          if (cur_left != '0) begin
            data_left_next = cur_left - 1'b1;
          end
          if (data_left_next == '0) begin
            phase_next = PH_DATA_CR;
          end
        end
        PH_DATA_CR: begin
          if (b != hcbd_pkg::CHAR_CR) begin
            err = hcbd_pkg::ERR_MISSING_CRLF;
          end else begin
            take = 1'b1;
            cls  = hcbd_pkg::CLS_DATA_CRLF;
            phase_next = PH_DATA_LF;
          end
        end
        PH_DATA_LF: begin
          if (b != hcbd_pkg::CHAR_LF) begin
            err = hcbd_pkg::ERR_MISSING_CRLF;
          end else begin
            take = 1'b1;
            cls  = hcbd_pkg::CLS_DATA_CRLF;
            phase_next          = PH_SIZE;
            chunk_size_acc_next = '0;
            line_count_next     = '0;
            saw_digit_next      = 1'b0;
          end
        end
        PH_TR_START: begin
          line_count_next = '0;
          if (b == hcbd_pkg::CHAR_LF) begin
            err = hcbd_pkg::ERR_TRAILER_LINE;
          end else begin
            take = 1'b1;
            if (b == hcbd_pkg::CHAR_CR) begin
              phase_next = PH_FINAL_LF;
              cls = hcbd_pkg::CLS_FINAL_CRLF;
            end else begin
              phase_next = PH_TR;
              cls = hcbd_pkg::CLS_TRAILER;
            end
          end
        end
        PH_TR: begin
          line_count_next = count_inc;
          if (count_inc > {1'b0, trailer_line_limit} || b == hcbd_pkg::CHAR_LF) begin
            err = hcbd_pkg::ERR_TRAILER_LINE;
          end else begin
            take = 1'b1;
            cls  = hcbd_pkg::CLS_TRAILER;
            if (b == hcbd_pkg::CHAR_CR) begin
              phase_next = PH_TR_LF;
            end
          end
        end
        PH_TR_LF: begin
          if (b != hcbd_pkg::CHAR_LF) begin
            err = hcbd_pkg::ERR_MISSING_CRLF;
          end else begin
            take = 1'b1;
            cls  = hcbd_pkg::CLS_TRAILER;
            phase_next = PH_TR_START;
          end
        end
        PH_FINAL_LF: begin
          if (b != hcbd_pkg::CHAR_LF) begin
            err = hcbd_pkg::ERR_MISSING_CRLF;
          end else begin
            take = 1'b1;
            cls  = hcbd_pkg::CLS_FINAL_CRLF;
            phase_next = PH_DONE;
          end
        end
        default: begin
          // Done, or a code that cannot arise: nothing consumed
          take = 1'b0;
        end
      endcase
    end

    error_held_next = (err != hcbd_pkg::ERR_OK) ? err : cur_err;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      ext_line_limit     <= hcbd_pkg::EXT_LINE_LIMIT_RST;
      trailer_line_limit <= hcbd_pkg::TRAILER_LINE_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        hcbd_pkg::CFG_EXT_LINE_LIMIT:     ext_line_limit     <= cfg_data;
        hcbd_pkg::CFG_TRAILER_LINE_LIMIT: trailer_line_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register: hold while the result register is blocked
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
    if (in_take) begin
      s1_item <= in_data;
    end
  end

  // Parser state and result register: advance on each transfer out of the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_SIZE;
      chunk_size_acc <= '0;
      data_left      <= '0;
      line_count     <= '0;
      saw_digit      <= 1'b0;
      error_held     <= hcbd_pkg::ERR_OK;
      out_valid      <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
      if (s1_valid) begin
        phase          <= phase_next;
        chunk_size_acc <= chunk_size_acc_next;
        data_left      <= data_left_next;
        line_count     <= line_count_next;
        saw_digit      <= saw_digit_next;
        error_held     <= error_held_next;
      end
    end
    if (advance && s1_valid) begin
      out_data.consumed   <= take;
      out_data.byte_class <= take ? cls : hcbd_pkg::CLS_NONE;
      out_data.body_done  <= (phase_next == PH_DONE);
      out_data.error_code <= error_held_next;
    end
  end

endmodule
